// File: hdl/bxavg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bxavg_pkg
// Shared types and constants of the box average image downscaler.
// ----------------------------------------------------------------------------
package bxavg_pkg;

  localparam int NCH        = 4;
  localparam int PIX_W      = 8;
  localparam int COL_W      = 11;
  localparam int ROW_W      = 12;
  localparam int BLK_REG_W  = 5;
  localparam int IW_REG_W   = 12;
  localparam int IH_REG_W   = 13;
  localparam int MAX_HEIGHT = 4096;
  localparam int QUOT_W     = 8;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  typedef enum logic [1:0] {
    REG_BLOCK_WIDTH,
    REG_BLOCK_HEIGHT,
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT
  } reg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
    logic [PIX_W-1:0] alpha_in;
  } pixel_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;
    logic [PIX_W-1:0] alpha_out;
    logic [COL_W-1:0] out_column;
    logic [ROW_W-1:0] out_row;
    logic             end_of_image;
  } result_t;

endpackage

// File: hdl/bxavg_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bxavg_ifs
// Valid/ready channels for source pixels and averaged result pixels.
// ----------------------------------------------------------------------------
interface bxavg_pix_if;
  logic              valid;
  logic              ready;
  bxavg_pkg::pixel_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bxavg_res_if;
  logic               valid;
  logic               ready;
  bxavg_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/box_average_image_downscale_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_average_image_downscale_core
// Shrinks an RGBA raster image by whole factors with per-channel box averages.
// ----------------------------------------------------------------------------
// Source pixels enter in raster order on the pixels channel, each request one
// RGBA pixel. Averaged pixels leave on the results channel together with their
// position in the reduced image and an end-of-image flag. Block and image sizes
// are set through the APB port; any register write restarts the frame.
// Column sums of the current block row live in one single-port-write,
// registered-read memory of MAX_WIDTH entries, updated read-modify-write.
// Work per source pixel:
//   pixel inside a block column          added to the run sum, input stays open
//   pixel closing a block column         memory read, then write; input closed
//   pixel closing a whole block          read, write, 8-step divider; input closed
// After the last divide step the averaged pixel goes to the output register.
// The result sits in an output register; new pixels are taken while it waits.
// If the receiver stalls and the next result is ready, the divider holds it
// and the input stops until the output register frees up.
// Reset restores the default registers (1x1 blocks, 2048x4096 image) and the
// frame position; the sum memory needs no clearing pass, the first row of each
// block row overwrites its entries.
// ----------------------------------------------------------------------------
module box_average_image_downscale_core #(
  parameter int MAX_WIDTH = 2048,
  parameter int MAX_BLOCK = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bxavg_pkg::ADDR_W-1:0]  paddr,
  input  logic [bxavg_pkg::DATA_W-1:0]  pwdata,
  output logic [bxavg_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  bxavg_pix_if.sink                     pixels,
  bxavg_res_if.source                   results
);
  import bxavg_pkg::*;

  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int IWW   = $clog2(MAX_WIDTH + 1);
  localparam int BW    = $clog2(MAX_BLOCK + 1);
  localparam int CBW   = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam int CNTW  = 2 * BW;
  localparam int RW    = $clog2(MAX_BLOCK * 255 + 1);
  localparam int SW    = $clog2(MAX_BLOCK * MAX_BLOCK * 255 + 1);
  localparam int DW    = CNTW + QUOT_W - 1;
  localparam int STEPW = $clog2(QUOT_W);

  typedef enum logic [1:0] {S_IDLE, S_UPD, S_DIV, S_HOLD} state_t;
  typedef logic [NCH-1:0][SW-1:0] sums_t;
  typedef logic [NCH-1:0][RW-1:0] runs_t;
  typedef logic [NCH-1:0][QUOT_W-1:0] quots_t;

  state_t               state;
  logic [BLK_REG_W-1:0] block_width;
  logic [BLK_REG_W-1:0] block_height;
  logic [IW_REG_W-1:0]  image_width;
  logic [IH_REG_W-1:0]  image_height;

  logic [CW-1:0]        sc;
  logic [ROW_W-1:0]     sr;
  logic [CBW-1:0]       cib;
  logic [CBW-1:0]       rib;
  logic [CW-1:0]        ocol;
  logic [ROW_W-1:0]     orow;
  runs_t                run;

  logic [CW-1:0]        upd_addr;
  runs_t                upd_run;
  logic                 upd_first;
  logic                 upd_emit;
  logic [CNTW-1:0]      upd_count;
  logic [ROW_W-1:0]     upd_row;
  logic                 upd_eoi;

  sums_t                mem [MAX_WIDTH];
  sums_t                rdata;

  sums_t                rem;
  logic [DW-1:0]        dshift;
  quots_t               quot;
  logic [STEPW-1:0]     step;

  logic                 res_valid;
  result_t              res_data;

  logic [BW-1:0]        bw_eff;
  logic [BW-1:0]        bh_eff;
  logic [IWW-1:0]       iw_eff;
  logic [IH_REG_W-1:0]  ih_eff;
  logic                 restart;
  logic [CW-1:0]        e_sc;
  logic [ROW_W-1:0]     e_sr;
  logic [CBW-1:0]       e_cib;
  logic [CBW-1:0]       e_rib;
  logic [CW-1:0]        e_ocol;
  logic [ROW_W-1:0]     e_orow;
  runs_t                run_new;
  logic [NCH-1:0][PIX_W-1:0] pix_ch;
  logic                 end_row;
  logic                 last_row;
  logic                 end_col;
  logic                 end_rb;
  logic [CNTW-1:0]      count_new;
  sums_t                sum_new;
  sums_t                rem_next;
  quots_t               quot_next;
  logic                 accept;
  logic                 cfg_wr;
  logic                 can_load;
  logic                 res_load;
  reg_idx_t             cfg_idx;

  assign pready         = 1'b1;
  assign cfg_wr         = psel && penable && pwrite;
  assign cfg_idx        = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign pixels.ready   = (state == S_IDLE);
  assign accept         = pixels.valid && (state == S_IDLE);
  assign results.valid  = res_valid;
  assign results.data   = res_data;
  assign can_load       = !res_valid || results.ready;
  assign res_load       = can_load && ((state == S_HOLD) ||
                          ((state == S_DIV) && (step == STEPW'(QUOT_W - 1))));

  always_comb begin
    case (cfg_idx)
      REG_BLOCK_WIDTH:  prdata = DATA_W'(block_width);
      REG_BLOCK_HEIGHT: prdata = DATA_W'(block_height);
      REG_IMAGE_WIDTH:  prdata = DATA_W'(image_width);
      REG_IMAGE_HEIGHT: prdata = DATA_W'(image_height);
      default:          prdata = '0;
    endcase
  end

  // effective sizes
  always_comb begin
    if (block_width == '0) begin
      bw_eff = BW'(1);
    end else if (32'(block_width) > MAX_BLOCK) begin
      bw_eff = BW'(MAX_BLOCK);
    end else begin
      bw_eff = BW'(block_width);
    end
    if (block_height == '0) begin
      bh_eff = BW'(1);
    end else if (32'(block_height) > MAX_BLOCK) begin
      bh_eff = BW'(MAX_BLOCK);
    end else begin
      bh_eff = BW'(block_height);
    end
    if (image_width == '0) begin
      iw_eff = IWW'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      iw_eff = IWW'(MAX_WIDTH);
    end else begin
      iw_eff = IWW'(image_width);
    end
    if (image_height == '0) begin
      ih_eff = IH_REG_W'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      ih_eff = IH_REG_W'(MAX_HEIGHT);
    end else begin
      ih_eff = image_height;
    end
  end

  // position and run sum for the pixel on the input
  always_comb begin
    pix_ch[0] = pixels.data.red_in;
    pix_ch[1] = pixels.data.green_in;
    pix_ch[2] = pixels.data.blue_in;
    pix_ch[3] = pixels.data.alpha_in;
    restart = (32'(sc) >= 32'(iw_eff)) || (32'(sr) >= 32'(ih_eff)) ||
              (32'(cib) >= 32'(bw_eff)) || (32'(rib) >= 32'(bh_eff));
    e_sc   = restart ? '0 : sc;
    e_sr   = restart ? '0 : sr;
    e_cib  = restart ? '0 : cib;
    e_rib  = restart ? '0 : rib;
    e_ocol = restart ? '0 : ocol;
    e_orow = restart ? '0 : orow;
    for (int c = 0; c < NCH; c++) begin
      run_new[c] = (restart ? RW'(0) : run[c]) + RW'(pix_ch[c]);
    end
    end_row   = (32'(e_sc) + 1 >= 32'(iw_eff));
    last_row  = (32'(e_sr) + 1 >= 32'(ih_eff));
    end_col   = end_row || (32'(e_cib) + 1 >= 32'(bw_eff));
    end_rb    = last_row || (32'(e_rib) + 1 >= 32'(bh_eff));
    count_new = CNTW'(BW'(BW'(e_cib) + BW'(1))) * CNTW'(BW'(BW'(e_rib) + BW'(1)));
  end

  // column sum update and one restoring divide step per channel
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      sum_new[c] = upd_first ? SW'(upd_run[c]) : rdata[c] + SW'(upd_run[c]);
      if (32'(rem[c]) >= 32'(dshift)) begin
        rem_next[c]  = rem[c] - SW'(dshift);
        quot_next[c] = {quot[c][QUOT_W-2:0], 1'b1};
      end else begin
        rem_next[c]  = rem[c];
        quot_next[c] = {quot[c][QUOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && end_col) begin
      rdata <= mem[e_ocol];
    end
    if (state == S_UPD) begin
      mem[upd_addr] <= sum_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      block_width  <= BLK_REG_W'(1);
      block_height <= BLK_REG_W'(1);
      image_width  <= IW_REG_W'(2048);
      image_height <= IH_REG_W'(4096);
      sc           <= '0;
      sr           <= '0;
      cib          <= '0;
      rib          <= '0;
      ocol         <= '0;
      orow         <= '0;
      run          <= '0;
      res_valid    <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && results.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pixels.valid) begin
            if (end_col) begin
              upd_addr  <= e_ocol;
              upd_run   <= run_new;
              upd_first <= (e_rib == '0);
              upd_emit  <= end_rb;
              upd_count <= count_new;
              upd_row   <= e_orow;
              upd_eoi   <= end_row && last_row;
              run       <= '0;
              cib       <= '0;
              ocol      <= end_row ? '0 : e_ocol + CW'(1);
              state     <= S_UPD;
            end else begin
              run  <= run_new;
              cib  <= e_cib + CBW'(1);
              ocol <= e_ocol;
            end
            if (end_row) begin
              sc   <= '0;
              rib  <= end_rb ? '0 : e_rib + CBW'(1);
              sr   <= last_row ? '0 : e_sr + ROW_W'(1);
              orow <= end_rb ? (last_row ? '0 : e_orow + ROW_W'(1)) : e_orow;
            end else begin
              sc   <= e_sc + CW'(1);
              rib  <= e_rib;
              sr   <= e_sr;
              orow <= e_orow;
            end
          end
        end
        S_UPD: begin
          if (upd_emit) begin
            rem    <= sum_new;
            dshift <= DW'(upd_count) << (QUOT_W - 1);
            quot   <= '0;
            step   <= '0;
            state  <= S_DIV;
          end else begin
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          rem    <= rem_next;
          quot   <= quot_next;
          dshift <= dshift >> 1;
          step   <= step + STEPW'(1);
          if (step == STEPW'(QUOT_W - 1)) begin
            if (can_load) begin
              res_data.red_out       <= quot_next[0];
              res_data.green_out     <= quot_next[1];
              res_data.blue_out      <= quot_next[2];
              res_data.alpha_out     <= quot_next[3];
              res_data.out_column    <= COL_W'(upd_addr);
              res_data.out_row       <= upd_row;
              res_data.end_of_image  <= upd_eoi;
              state                  <= S_IDLE;
            end else begin
              state <= S_HOLD;
            end
          end
        end
        S_HOLD: begin
          if (can_load) begin
            res_data.red_out       <= quot[0];
            res_data.green_out     <= quot[1];
            res_data.blue_out      <= quot[2];
            res_data.alpha_out     <= quot[3];
            res_data.out_column    <= COL_W'(upd_addr);
            res_data.out_row       <= upd_row;
            res_data.end_of_image  <= upd_eoi;
            state                  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cfg_wr) begin
        case (cfg_idx)
          REG_BLOCK_WIDTH:  block_width  <= pwdata[BLK_REG_W-1:0];
          REG_BLOCK_HEIGHT: block_height <= pwdata[BLK_REG_W-1:0];
          REG_IMAGE_WIDTH:  image_width  <= pwdata[IW_REG_W-1:0];
          REG_IMAGE_HEIGHT: image_height <= pwdata[IH_REG_W-1:0];
          default: ;
        endcase
        sc   <= '0;
        sr   <= '0;
        cib  <= '0;
        rib  <= '0;
        ocol <= '0;
        orow <= '0;
        run  <= '0;
      end
    end
  end

endmodule

// File: hdl/bxavg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bxavg_checker
// Port-level checks of the box average downscaler, bound to the top level.
// ----------------------------------------------------------------------------
module bxavg_checker (
  input logic               clk,
  input logic               rst,
  input logic               pix_valid,
  input logic               pix_ready,
  input logic               res_valid,
  input logic               res_ready,
  input bxavg_pkg::result_t res_data
);

  // idle and empty right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !res_valid && pix_ready)
    else $error("not idle after reset");

  // a new result is only loaded while the input is blocked
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> !$past(pix_ready))
    else $error("result appeared while input was open");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped under stall");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_data))
    else $error("result changed under stall");

endmodule

bind box_average_image_downscale_core bxavg_checker u_bxavg_checker (
  .clk       (clk),
  .rst       (rst),
  .pix_valid (pixels.valid),
  .pix_ready (pixels.ready),
  .res_valid (results.valid),
  .res_ready (results.ready),
  .res_data  (results.data)
);

// File: dv/tb_box_average_image_downscale_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_average_image_downscale_core
// Self-checking bench for the box average image downscaler.
// ----------------------------------------------------------------------------
// Source pixels are pushed through the pixel channel while block and image
// sizes are changed over APB between runs. A scoreboard class keeps its own
// model of the column sums and frame position, predicts every averaged pixel
// on acceptance and compares the result channel field by field. Both channels
// see random gaps and stalls; sizes cover zero, oversized and partial blocks.
// ----------------------------------------------------------------------------
module tb_box_average_image_downscale_core;
  import bxavg_pkg::*;

  localparam int WIDTH_CAP      = 2048;
  localparam int BLOCK_CAP      = 16;
  localparam int REG_COUNT      = int'(REG_IMAGE_HEIGHT) + 1;
  localparam int SETTLE_CYCLES  = 40;
  localparam int RANDOM_ITEMS   = 1630;
  localparam int TIMEOUT_CYCLES = 1000000;

  class box_avg_sb;
    result_t                   pending_avgs[$];
    int unsigned               mismatches;
    logic [BLK_REG_W-1:0]      bw_reg;
    logic [BLK_REG_W-1:0]      bh_reg;
    logic [IW_REG_W-1:0]       iw_reg;
    logic [IH_REG_W-1:0]       ih_reg;
    int unsigned               col_sum [WIDTH_CAP][NCH];
    int unsigned               run_sum [NCH];
    logic [COL_W-1:0]          src_col;
    logic [ROW_W-1:0]          src_row;
    logic [3:0]                col_in_blk;
    logic [3:0]                row_in_blk;

    function new();
      mismatches = 0;
      bw_reg = 1;
      bh_reg = 1;
      iw_reg = 2048;
      ih_reg = 4096;
      restart();
    endfunction

    function void restart();
      for (int c = 0; c < NCH; c++) run_sum[c] = 0;
      src_col = 0;
      src_row = 0;
      col_in_blk = 0;
      row_in_blk = 0;
    endfunction

    function int unsigned clamp_size(int unsigned v, int unsigned hi);
      return (v == 0) ? 1 : ((v > hi) ? hi : v);
    endfunction

    function void write_reg(reg_idx_t idx, logic [DATA_W-1:0] v);
      case (idx)
        REG_BLOCK_WIDTH:  bw_reg = v[BLK_REG_W-1:0];
        REG_BLOCK_HEIGHT: bh_reg = v[BLK_REG_W-1:0];
        REG_IMAGE_WIDTH:  iw_reg = v[IW_REG_W-1:0];
        REG_IMAGE_HEIGHT: ih_reg = v[IH_REG_W-1:0];
        default: ;
      endcase
      restart();
    endfunction

    function void note_pixel(pixel_t p);
      int unsigned bw, bh, iw, ih, oc, cnt;
      int unsigned chan [NCH];
      bit end_row, last_row, end_cblk, end_rblk;
      result_t r;
      bw = clamp_size(bw_reg, BLOCK_CAP);
      bh = clamp_size(bh_reg, BLOCK_CAP);
      iw = clamp_size(iw_reg, WIDTH_CAP);
      ih = clamp_size(ih_reg, MAX_HEIGHT);
      if (src_col >= iw || src_row >= ih || col_in_blk >= bw || row_in_blk >= bh) restart();
      chan[0] = p.red_in;
      chan[1] = p.green_in;
      chan[2] = p.blue_in;
      chan[3] = p.alpha_in;
      for (int c = 0; c < NCH; c++) run_sum[c] += chan[c];
      end_row  = (src_col + 1 >= iw);
      last_row = (src_row + 1 >= ih);
      end_cblk = end_row || (col_in_blk + 1 >= bw);
      end_rblk = last_row || (row_in_blk + 1 >= bh);
      oc = src_col / bw;
      if (end_cblk) begin
        // first row of a block row overwrites stale sums
        for (int c = 0; c < NCH; c++) begin
          if (row_in_blk == 0) col_sum[oc][c] = run_sum[c];
          else col_sum[oc][c] += run_sum[c];
          run_sum[c] = 0;
        end
        if (end_rblk) begin
          cnt = (col_in_blk + 1) * (row_in_blk + 1);
          r.red_out      = PIX_W'(col_sum[oc][0] / cnt);
          r.green_out    = PIX_W'(col_sum[oc][1] / cnt);
          r.blue_out     = PIX_W'(col_sum[oc][2] / cnt);
          r.alpha_out    = PIX_W'(col_sum[oc][3] / cnt);
          r.out_column   = COL_W'(oc);
          r.out_row      = ROW_W'(src_row / bh);
          r.end_of_image = end_row && last_row;
          pending_avgs.push_back(r);
        end
        col_in_blk = 0;
      end else begin
        col_in_blk++;
      end
      if (end_row) begin
        src_col = 0;
        row_in_blk = end_rblk ? 4'd0 : row_in_blk + 4'd1;
        src_row = last_row ? ROW_W'(0) : src_row + ROW_W'(1);
      end else begin
        src_col++;
      end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_avgs.size() == 0) begin
        $error("unexpected result: column %0d row %0d", got.out_column, got.out_row);
        mismatches++;
      end else begin
        want = pending_avgs.pop_front();
        compare_field("red_out", want.red_out, got.red_out);
        compare_field("green_out", want.green_out, got.green_out);
        compare_field("blue_out", want.blue_out, got.blue_out);
        compare_field("alpha_out", want.alpha_out, got.alpha_out);
        compare_field("out_column", want.out_column, got.out_column);
        compare_field("out_row", want.out_row, got.out_row);
        compare_field("end_of_image", want.end_of_image, got.end_of_image);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int unsigned       cycle_count = 0;
  bit                tx_gaps_on;
  box_avg_sb         sb;

  bxavg_pix_if pix_if ();
  bxavg_res_if res_if ();

  box_average_image_downscale_core #(
    .MAX_WIDTH(WIDTH_CAP),
    .MAX_BLOCK(BLOCK_CAP)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pixels  (pix_if),
    .results (res_if)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == TIMEOUT_CYCLES) begin
      $display("box_average_image_downscale_core: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) sb.check_result(res_if.data);
  end

  // result backpressure
  initial begin
    int unsigned run, stall, r;
    forever begin
      r = $urandom_range(0, 99);
      run = (r < 15) ? $urandom_range(100, 300) : $urandom_range(1, 6);
      res_if.ready <= 1'b1;
      repeat (run) @(posedge clk);
      r = $urandom_range(0, 99);
      if (r < 70) stall = $urandom_range(1, 3);
      else if (r < 92) stall = $urandom_range(4, 10);
      else stall = $urandom_range(20, 60);
      res_if.ready <= 1'b0;
      repeat (stall) @(posedge clk);
    end
  end

  task automatic feed(pixel_t p);
    int unsigned r, gap;
    pix_if.valid <= 1'b1;
    pix_if.data <= p;
    do @(posedge clk); while (!pix_if.ready);
    sb.note_pixel(p);
    gap = 0;
    if (tx_gaps_on) begin
      r = $urandom_range(0, 99);
      if (r >= 95) gap = $urandom_range(10, 40);
      else if (r >= 65) gap = $urandom_range(1, 3);
    end
    if (gap != 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    pix_if.valid <= 1'b0;
    while (sb.pending_avgs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(logic [DATA_W-1:0] bw, logic [DATA_W-1:0] bh,
                           logic [DATA_W-1:0] iw, logic [DATA_W-1:0] ih);
    logic [DATA_W-1:0] vals [REG_COUNT];
    vals[REG_BLOCK_WIDTH]  = bw;
    vals[REG_BLOCK_HEIGHT] = bh;
    vals[REG_IMAGE_WIDTH]  = iw;
    vals[REG_IMAGE_HEIGHT] = ih;
    settle();
    for (int i = 0; i < REG_COUNT; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'(4 * i);
      pwdata  <= vals[i];
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      sb.write_reg(reg_idx_t'(i), vals[i]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] pick_reg(reg_idx_t idx);
    logic [DATA_W-1:0] v;
    int unsigned r, w;
    r = $urandom_range(0, 99);
    case (idx)
      REG_BLOCK_WIDTH, REG_BLOCK_HEIGHT: begin
        w = BLK_REG_W;
        if (r < 10) begin
          case ($urandom_range(0, 3))
            0: v = 0;
            1: v = 16;
            2: v = 17;
            default: v = 31;
          endcase
        end else if (r < 40) begin
          v = $urandom_range(1, 16);
        end else begin
          v = $urandom_range(1, 4);
        end
      end
      REG_IMAGE_WIDTH: begin
        w = IW_REG_W;
        if (r < 8) begin
          case ($urandom_range(0, 3))
            0: v = 0;
            1: v = 2048;
            2: v = 2049;
            default: v = 4095;
          endcase
        end else if (r < 20) begin
          v = $urandom_range(41, 300);
        end else begin
          v = $urandom_range(1, 40);
        end
      end
      default: begin
        w = IH_REG_W;
        if (r < 8) begin
          case ($urandom_range(0, 3))
            0: v = 0;
            1: v = 4096;
            2: v = 4097;
            default: v = 8191;
          endcase
        end else begin
          v = $urandom_range(1, 16);
        end
      end
    endcase
    // junk above the register field
    if ($urandom_range(0, 3) == 0) v = v | ($urandom << w);
    return v;
  endfunction

  initial begin
    logic [DATA_W-1:0] cfg [REG_COUNT];
    int unsigned total, n, frame, pause_at, r;
    bit first;
    pixel_t px;
    sb = new();
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    pix_if.valid <= 1'b0;
    pix_if.data <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset sizes: every pixel is its own block
    tx_gaps_on = 1'b1;
    feed(32'h0000_0000);
    feed(32'hFFFF_FFFF);
    feed(32'hFF00_0000);
    feed(32'h00FF_0000);
    feed(32'h0000_FF00);
    feed(32'h0000_00FF);
    feed(32'h55AA_55AA);
    feed(32'hAA55_AA55);
    feed(32'h0180_8001);

    // zero sizes act as one, every pixel ends the image
    configure(0, 0, 0, 0);
    repeat (3) feed($urandom);

    // oversized blocks clipped to a partial 3x2 block, truncating divide
    configure(31, 31, 3, 2);
    repeat (5) feed(32'hFFFF_FFFF);
    feed(32'hFEFE_FEFE);

    // oversized image
    configure(2, 1, 4095, 8191);
    repeat (4) feed($urandom);

    total = 0;
    first = 1'b1;
    while (total < RANDOM_ITEMS) begin
      for (int i = 0; i < REG_COUNT; i++) cfg[i] = pick_reg(reg_idx_t'(i));
      configure(cfg[REG_BLOCK_WIDTH], cfg[REG_BLOCK_HEIGHT],
                cfg[REG_IMAGE_WIDTH], cfg[REG_IMAGE_HEIGHT]);
      frame = sb.clamp_size(cfg[REG_IMAGE_WIDTH][IW_REG_W-1:0], WIDTH_CAP) *
              sb.clamp_size(cfg[REG_IMAGE_HEIGHT][IH_REG_W-1:0], MAX_HEIGHT);
      if (frame <= 200) n = frame * $urandom_range(1, 2) + $urandom_range(0, frame);
      else n = $urandom_range(30, 200);
      if (n > 300) n = 300;
      if (n > RANDOM_ITEMS - total) n = RANDOM_ITEMS - total;
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      pause_at = (first || $urandom_range(0, 2) == 0) ? $urandom_range(0, n - 1) : n;
      for (int k = 0; k < n; k++) begin
        if (k == pause_at) settle();
        r = $urandom_range(0, 7);
        if (r == 0) px = '1;
        else if (r == 1) px = '0;
        else px = $urandom;
        feed(px);
      end
      total += n;
      first = 1'b0;
    end

    settle();
    if (sb.mismatches == 0 && sb.pending_avgs.size() == 0) begin
      $display("box_average_image_downscale_core: match");
    end else begin
      $display("box_average_image_downscale_core: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/bxavg_pkg.sv
hdl/bxavg_ifs.sv
hdl/box_average_image_downscale_core.sv
hdl/bxavg_checker.sv
dv/tb_box_average_image_downscale_core.sv
